// File: hdl/bais_pkg.sv
`default_nettype none
package bais_pkg;
	localparam int SRC_DIM = 256;
	localparam int TGT_DIM = 4096;
	localparam int AW = 16;
	localparam int SUMW = 24;
	localparam int AREAW = 17;

	localparam logic [2:0] REG_IMG_W = 3'd0;
	localparam logic [2:0] REG_IMG_H = 3'd1;
	localparam logic [2:0] REG_CROP_L = 3'd2;
	localparam logic [2:0] REG_CROP_T = 3'd3;
	localparam logic [2:0] REG_CROP_W = 3'd4;
	localparam logic [2:0] REG_CROP_H = 3'd5;
	localparam logic [2:0] REG_TGT_W = 3'd6;
	localparam logic [2:0] REG_TGT_H = 3'd7;

	typedef struct packed {
		logic load_span;
		logic div_start;
		logic div_sel_y;
		logic fix_span;
		logic clr_acc;
		logic rd_en;
		logic acc_en;
		logic step;
		logic area_start;
		logic avg_start;
		logic cap_res;
		logic bad;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic last_px;
		logic avg_done;
	} sts_t;
endpackage
`default_nettype wire

// File: hdl/bais_ctrl.sv
`default_nettype none
module bais_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic valid_req,
	input wire logic out_free,
	input wire bais_pkg::sts_t sts,
	output bais_pkg::cmd_t cmd,
	output logic busy,
	output logic res_valid_set
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DIVX0 = 4'd1;
	localparam logic [3:0] S_DIVX1 = 4'd2;
	localparam logic [3:0] S_DIVY0 = 4'd3;
	localparam logic [3:0] S_DIVY1 = 4'd4;
	localparam logic [3:0] S_FIX = 4'd5;
	localparam logic [3:0] S_WALK = 4'd6;
	localparam logic [3:0] S_DRAIN = 4'd7;
	localparam logic [3:0] S_AVG = 4'd8;
	localparam logic [3:0] S_OUT = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic [1:0] drain_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		res_valid_set = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (valid_req) begin
						cmd.load_span = 1'b1;
						state_d = S_DIVX0;
					end else begin
						cmd.bad = 1'b1;
						state_d = S_OUT;
					end
				end
			end
			S_DIVX0, S_DIVX1, S_DIVY0, S_DIVY1: begin
				cmd.div_sel_y = (state_q == S_DIVY0) || (state_q == S_DIVY1);
				if ((state_q == S_DIVX0) || (state_q == S_DIVY0)) begin
					cmd.div_start = 1'b1;
					state_d = state_q + 4'd1;
				end else if (sts.div_done) begin
					state_d = state_q + 4'd1;
				end
			end
			S_FIX: begin
				cmd.fix_span = 1'b1;
				cmd.clr_acc = 1'b1;
				state_d = S_WALK;
			end
			S_WALK: begin
				cmd.rd_en = 1'b1;
				cmd.step = 1'b1;
				if (sts.last_px) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				cmd.acc_en = (drain_q == 2'd0);
				if (drain_q == 2'd1) begin
					cmd.avg_start = 1'b1;
					state_d = S_AVG;
				end
			end
			S_AVG: begin
				if (sts.avg_done) begin
					cmd.cap_res = 1'b1;
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (out_free) begin
					res_valid_set = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		if (state_q == S_WALK) cmd.acc_en = drain_q != 2'd3;
		cmd.area_start = (state_q == S_FIX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			drain_q <= 2'd3;
		end else begin
			state_q <= state_d;
			if (state_q == S_FIX) drain_q <= 2'd3;
			else if (state_q == S_WALK) drain_q <= 2'd0;
			else if (state_q == S_DRAIN) drain_q <= drain_q + 2'd1;
			else drain_q <= 2'd3;
		end
	end

	assign busy = state_q != S_IDLE;

	a_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_set |=> state_q == S_IDLE) else $error("result without return to idle");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_span || cmd.bad) |-> !busy) else $error("request taken while busy");
	a_avg_walk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.avg_start |-> $past(state_q) == S_DRAIN) else $error("average before walk");
endmodule
`default_nettype wire

// File: hdl/bais_datapath.sv
`default_nettype none
module bais_datapath (
	input wire logic clk,
	input wire bais_pkg::cmd_t cmd,
	output bais_pkg::sts_t sts,
	input wire logic [7:0] crop_left,
	input wire logic [7:0] crop_top,
	input wire logic [8:0] crop_width,
	input wire logic [8:0] crop_height,
	input wire logic [12:0] target_width,
	input wire logic [12:0] target_height,
	input wire logic [11:0] tc,
	input wire logic [11:0] tr,
	input wire logic wr_en,
	input wire logic [bais_pkg::AW-1:0] wr_addr,
	input wire logic [23:0] wr_data,
	output logic [7:0] blue_res,
	output logic [7:0] green_res,
	output logic [7:0] red_res
);
	logic [23:0] mem [0:bais_pkg::SRC_DIM*bais_pkg::SRC_DIM-1];
	logic [23:0] rd_q;

	// span operands: numerators o*len and (o+1)*len, up to 21 bits
	logic [20:0] nx0_q, nx1_q, ny0_q, ny1_q;
	logic [8:0] qa_q, qb_q, qc_q, qd_q;
	logic [9:0] x0_q, x1_q, y1_q, x_q, y_q;

	// shared restoring divider, two dividends in parallel over one divisor
	logic [20:0] dv0_q, dv1_q;
	logic [13:0] r0_q, r1_q;
	logic [12:0] den_q;
	logic [4:0] dcnt_q;
	logic dbusy_q;
	logic [13:0] r0n, r1n;
	logic ge0, ge1;

	always_comb begin
		r0n = {r0_q[12:0], dv0_q[20]};
		r1n = {r1_q[12:0], dv1_q[20]};
		ge0 = r0n >= {1'b0, den_q};
		ge1 = r1n >= {1'b0, den_q};
	end

	always_ff @(posedge clk) begin
		if (cmd.load_span) begin
			nx0_q <= 21'(tc) * 21'(crop_width);
			nx1_q <= (21'(tc) + 21'd1) * 21'(crop_width);
			ny0_q <= 21'(tr) * 21'(crop_height);
			ny1_q <= (21'(tr) + 21'd1) * 21'(crop_height);
			dbusy_q <= 1'b0;
		end else if (cmd.div_start) begin
			dv0_q <= cmd.div_sel_y ? ny0_q : nx0_q;
			dv1_q <= cmd.div_sel_y ? ny1_q : nx1_q;
			den_q <= cmd.div_sel_y ? target_height : target_width;
			r0_q <= '0;
			r1_q <= '0;
			dcnt_q <= 5'd21;
			dbusy_q <= 1'b1;
		end else if (dbusy_q) begin
			dv0_q <= {dv0_q[19:0], ge0};
			dv1_q <= {dv1_q[19:0], ge1};
			r0_q <= ge0 ? r0n - {1'b0, den_q} : r0n;
			r1_q <= ge1 ? r1n - {1'b0, den_q} : r1n;
			dcnt_q <= dcnt_q - 5'd1;
			if (dcnt_q == 5'd1) begin
				dbusy_q <= 1'b0;
			end
		end
	end

	logic ddone_q;
	logic sel_y_q;
	always_ff @(posedge clk) begin
		ddone_q <= dbusy_q && dcnt_q == 5'd1;
		sel_y_q <= cmd.div_sel_y;
		if (ddone_q) begin
			if (sel_y_q) begin
				qc_q <= dv0_q[8:0];
				qd_q <= dv1_q[8:0];
			end else begin
				qa_q <= dv0_q[8:0];
				qb_q <= dv1_q[8:0];
			end
		end
	end
	assign sts.div_done = ddone_q;

	// span fixup: widen to one pixel and clip to the crop
	logic [9:0] ax, bx, ay, by, ex, ey;
	always_comb begin
		ax = 10'(crop_left) + 10'(qa_q);
		bx = 10'(crop_left) + 10'(qb_q);
		ex = 10'(crop_left) + 10'(crop_width);
		if (bx <= ax) bx = ax + 10'd1;
		if (bx > ex) bx = ex;
		ay = 10'(crop_top) + 10'(qc_q);
		by = 10'(crop_top) + 10'(qd_q);
		ey = 10'(crop_top) + 10'(crop_height);
		if (by <= ay) by = ay + 10'd1;
		if (by > ey) by = ey;
	end

	logic last_x, last_y;
	assign last_x = (x_q + 10'd1) == x1_q;
	assign last_y = (y_q + 10'd1) == y1_q;
	assign sts.last_px = last_x && last_y;

	always_ff @(posedge clk) begin
		if (cmd.fix_span) begin
			x0_q <= ax;
			x1_q <= bx;
			y1_q <= by;
			x_q <= ax;
			y_q <= ay;
		end else if (cmd.step) begin
			if (last_x) begin
				x_q <= x0_q;
				y_q <= y_q + 10'd1;
			end else begin
				x_q <= x_q + 10'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (cmd.rd_en) rd_q <= mem[{y_q[7:0], x_q[7:0]}];
	end

	logic [bais_pkg::SUMW-1:0] sb_q, sg_q, sr_q;
	always_ff @(posedge clk) begin
		if (cmd.clr_acc) begin
			sb_q <= '0;
			sg_q <= '0;
			sr_q <= '0;
		end else if (cmd.acc_en) begin
			sb_q <= sb_q + 24'(rd_q[7:0]);
			sg_q <= sg_q + 24'(rd_q[15:8]);
			sr_q <= sr_q + 24'(rd_q[23:16]);
		end
	end

	logic [bais_pkg::AREAW-1:0] area_q;
	always_ff @(posedge clk) begin
		if (cmd.area_start) area_q <= 17'(bx - ax) * 17'(by - ay);
	end

	// three parallel restoring dividers, one quotient bit a cycle
	logic [23:0] quo_b_q, quo_g_q, quo_r_q;
	logic [17:0] rb_q, rg_q, rr_q;
	logic [4:0] acnt_q;
	logic abusy_q, adone_q;
	logic [17:0] rbn, rgn, rrn;
	always_comb begin
		rbn = {rb_q[16:0], quo_b_q[23]};
		rgn = {rg_q[16:0], quo_g_q[23]};
		rrn = {rr_q[16:0], quo_r_q[23]};
	end
	always_ff @(posedge clk) begin
		adone_q <= abusy_q && acnt_q == 5'd1 && !cmd.avg_start;
		if (cmd.avg_start) begin
			quo_b_q <= sb_q;
			quo_g_q <= sg_q;
			quo_r_q <= sr_q;
			rb_q <= '0;
			rg_q <= '0;
			rr_q <= '0;
			acnt_q <= 5'd24;
			abusy_q <= 1'b1;
		end else if (abusy_q) begin
			quo_b_q <= {quo_b_q[22:0], rbn >= 18'(area_q)};
			quo_g_q <= {quo_g_q[22:0], rgn >= 18'(area_q)};
			quo_r_q <= {quo_r_q[22:0], rrn >= 18'(area_q)};
			rb_q <= (rbn >= 18'(area_q)) ? rbn - 18'(area_q) : rbn;
			rg_q <= (rgn >= 18'(area_q)) ? rgn - 18'(area_q) : rgn;
			rr_q <= (rrn >= 18'(area_q)) ? rrn - 18'(area_q) : rrn;
			acnt_q <= acnt_q - 5'd1;
			if (acnt_q == 5'd1) begin
				abusy_q <= 1'b0;
			end
		end else begin
			abusy_q <= 1'b0;
		end
	end
	assign sts.avg_done = adone_q;

	always_ff @(posedge clk) begin
		if (cmd.bad) begin
			blue_res <= '0;
			green_res <= '0;
			red_res <= '0;
		end else if (cmd.cap_res) begin
			blue_res <= quo_b_q[7:0];
			green_res <= quo_g_q[7:0];
			red_res <= quo_r_q[7:0];
		end
	end
endmodule
`default_nettype wire

// File: hdl/box_average_image_scaler_top.sv
`default_nettype none
// channel | direction | handshake    | payload
// in      | input     | valid, stall | mode, load/target coordinates, bgr bytes
// out     | output    | valid, stall | blue/green/red averages, ok
// cfg     | input     | cfg_we       | cfg_index, cfg_data
//
// a load word is written straight into the frame store when it is taken
// a valid compute word stalls the input while it runs, for a w by h source box:
// two span divisions, one store read per box pixel, span fixup and drain, an average
// divide and the load of the output register
// an invalid request goes straight to the output state and loads its result word, with ok low
// reset restores register defaults; the frame store keeps no reset; a held result adds its wait
module box_average_image_scaler_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic mode,
	input wire logic [7:0] load_column,
	input wire logic [7:0] load_row,
	input wire logic [7:0] blue_in,
	input wire logic [7:0] green_in,
	input wire logic [7:0] red_in,
	input wire logic [11:0] target_column,
	input wire logic [11:0] target_row,
	output logic out_valid,
	input wire logic out_stall,
	output logic [7:0] blue_avg,
	output logic [7:0] green_avg,
	output logic [7:0] red_avg,
	output logic ok,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [12:0] cfg_data
);
	logic [8:0] img_w_q, img_h_q, crop_w_q, crop_h_q;
	logic [7:0] crop_l_q, crop_t_q;
	logic [12:0] tgt_w_q, tgt_h_q;
	logic [11:0] tc_q, tr_q;
	logic ok_q;

	// config writes, decoded by register index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= 9'd256;
			img_h_q <= 9'd256;
			crop_l_q <= 8'd0;
			crop_t_q <= 8'd0;
			crop_w_q <= 9'd256;
			crop_h_q <= 9'd256;
			tgt_w_q <= 13'd256;
			tgt_h_q <= 13'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bais_pkg::REG_IMG_W: img_w_q <= cfg_data[8:0];
				bais_pkg::REG_IMG_H: img_h_q <= cfg_data[8:0];
				bais_pkg::REG_CROP_L: crop_l_q <= cfg_data[7:0];
				bais_pkg::REG_CROP_T: crop_t_q <= cfg_data[7:0];
				bais_pkg::REG_CROP_W: crop_w_q <= cfg_data[8:0];
				bais_pkg::REG_CROP_H: crop_h_q <= cfg_data[8:0];
				bais_pkg::REG_TGT_W: tgt_w_q <= cfg_data;
				bais_pkg::REG_TGT_H: tgt_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic busy, res_set, take, start, valid_req, out_free;
	bais_pkg::cmd_t cmd;
	bais_pkg::sts_t sts;

	assign in_stall = busy;
	assign take = in_valid && !in_stall;
	assign start = take && mode;
	assign out_free = !out_valid || !out_stall;

	// request check against the live registers and coordinates
	always_comb begin
		valid_req = img_w_q != 9'd0 && img_h_q != 9'd0
			&& img_w_q <= 9'(bais_pkg::SRC_DIM) && img_h_q <= 9'(bais_pkg::SRC_DIM)
			&& crop_w_q != 9'd0 && crop_h_q != 9'd0
			&& tgt_w_q != 13'd0 && tgt_h_q != 13'd0
			&& tgt_w_q <= 13'(bais_pkg::TGT_DIM) && tgt_h_q <= 13'(bais_pkg::TGT_DIM)
			&& (10'(crop_l_q) + 10'(crop_w_q)) <= 10'(img_w_q)
			&& (10'(crop_t_q) + 10'(crop_h_q)) <= 10'(img_h_q)
			&& 13'(target_column) < tgt_w_q && 13'(target_row) < tgt_h_q;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			tc_q <= target_column;
			tr_q <= target_row;
			ok_q <= valid_req;
		end
	end

	bais_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .valid_req(valid_req),
		.out_free(out_free), .sts(sts), .cmd(cmd), .busy(busy),
		.res_valid_set(res_set)
	);

	logic [7:0] b_r, g_r, r_r;
	bais_datapath u_dp (
		.clk(clk), .cmd(cmd), .sts(sts),
		.crop_left(crop_l_q), .crop_top(crop_t_q),
		.crop_width(crop_w_q), .crop_height(crop_h_q),
		.target_width(tgt_w_q), .target_height(tgt_h_q),
		.tc(start ? target_column : tc_q), .tr(start ? target_row : tr_q),
		.wr_en(take && !mode), .wr_addr({load_row, load_column}),
		.wr_data({red_in, green_in, blue_in}),
		.blue_res(b_r), .green_res(g_r), .red_res(r_r)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (res_set) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (res_set) begin
			blue_avg <= b_r;
			green_avg <= g_r;
			red_avg <= r_r;
			ok <= ok_q;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(blue_avg)) else $error("result dropped");
	a_noacc: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !take) else $error("word taken while busy");
	a_bad0: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> blue_avg == 8'd0) else $error("invalid result not zero");
endmodule
`default_nettype wire

// File: bench/box_scale_checker.sv
`timescale 1ns / 1ps
module box_scale_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic mode,
	input wire logic [7:0] load_column,
	input wire logic [7:0] load_row,
	input wire logic [7:0] blue_in,
	input wire logic [7:0] green_in,
	input wire logic [7:0] red_in,
	input wire logic [11:0] target_column,
	input wire logic [11:0] target_row,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [7:0] blue_avg,
	input wire logic [7:0] green_avg,
	input wire logic [7:0] red_avg,
	input wire logic ok,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [12:0] cfg_data,
	output int errors,
	output int pending,
	output int results_seen,
	output int boxes_ok
);
	typedef struct packed {
		logic [7:0] b;
		logic [7:0] g;
		logic [7:0] r;
		logic ok;
	} pixel_avg_t;

	logic [23:0] frame [0:bais_pkg::SRC_DIM*bais_pkg::SRC_DIM-1];
	logic [12:0] regs [0:7];
	pixel_avg_t want_q [$];

	assign pending = want_q.size();

	function automatic void span(input int start, input int len, input int outn,
			input int o, output int lo, output int hi);
		lo = start + (o * len) / outn;
		hi = start + ((o + 1) * len) / outn;
		if (hi <= lo)
			hi = lo + 1;
		if (hi > start + len)
			hi = start + len;
	endfunction

	function automatic pixel_avg_t box_average(input int tc, input int tr);
		pixel_avg_t res;
		int iw, ih, cl, ct, cw, ch, tw, th;
		int x0, x1, y0, y1, sb, sg, sr, area;
		logic [23:0] px;
		iw = regs[bais_pkg::REG_IMG_W]; ih = regs[bais_pkg::REG_IMG_H];
		cl = regs[bais_pkg::REG_CROP_L]; ct = regs[bais_pkg::REG_CROP_T];
		cw = regs[bais_pkg::REG_CROP_W]; ch = regs[bais_pkg::REG_CROP_H];
		tw = regs[bais_pkg::REG_TGT_W]; th = regs[bais_pkg::REG_TGT_H];
		res = '0;
		if (iw == 0 || ih == 0 || iw > bais_pkg::SRC_DIM || ih > bais_pkg::SRC_DIM
				|| cw == 0 || ch == 0
				|| tw == 0 || th == 0 || tw > bais_pkg::TGT_DIM || th > bais_pkg::TGT_DIM
				|| cl + cw > iw || ct + ch > ih || tc >= tw || tr >= th)
			return res;
		span(cl, cw, tw, tc, x0, x1);
		span(ct, ch, th, tr, y0, y1);
		sb = 0; sg = 0; sr = 0;
		for (int y = y0; y < y1; y++)
			for (int x = x0; x < x1; x++) begin
				px = frame[(y * bais_pkg::SRC_DIM + x)
					% (bais_pkg::SRC_DIM * bais_pkg::SRC_DIM)];
				sb += px[7:0]; sg += px[15:8]; sr += px[23:16];
			end
		area = (x1 - x0) * (y1 - y0);
		res.b = 8'(sb / area); res.g = 8'(sg / area); res.r = 8'(sr / area);
		res.ok = 1'b1;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pixel_avg_t got, want;
		if (!arst_n) begin
			regs[0] = 256; regs[1] = 256; regs[2] = 0; regs[3] = 0;
			regs[4] = 256; regs[5] = 256; regs[6] = 256; regs[7] = 256;
			want_q.delete();
			errors = 0; results_seen = 0; boxes_ok = 0;
		end else begin
			if (cfg_we)
				case (cfg_index) inside
					bais_pkg::REG_CROP_L, bais_pkg::REG_CROP_T:
						regs[cfg_index] = 13'(cfg_data[7:0]);
					bais_pkg::REG_TGT_W, bais_pkg::REG_TGT_H:
						regs[cfg_index] = cfg_data;
					default: regs[cfg_index] = 13'(cfg_data[8:0]);
				endcase
			if (out_valid && !out_stall) begin
				got = '{blue_avg, green_avg, red_avg, ok};
				results_seen++;
				if (want_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected word b=%0d g=%0d r=%0d ok=%0b",
							blue_avg, green_avg, red_avg, ok);
				end else begin
					want = want_q.pop_front();
					if (got.ok) boxes_ok++;
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display("mismatch exp b=%0d g=%0d r=%0d ok=%0b got b=%0d g=%0d r=%0d ok=%0b",
								want.b, want.g, want.r, want.ok,
								blue_avg, green_avg, red_avg, ok);
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (mode == 1'b0)
					frame[{load_row, load_column}] = {red_in, green_in, blue_in};
				else
					want_q.push_back(box_average(target_column, target_row));
			end
		end
	end
endmodule

// File: bench/tb_box_average_image_scaler_top.sv
`timescale 1ns / 1ps
module tb_box_average_image_scaler_top;
	localparam int LIMIT = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0, in_stall;
	logic mode = 1'b0;
	logic [7:0] load_column = '0, load_row = '0;
	logic [7:0] blue_in = '0, green_in = '0, red_in = '0;
	logic [11:0] target_column = '0, target_row = '0;
	logic out_valid, out_stall = 1'b0;
	logic [7:0] blue_avg, green_avg, red_avg;
	logic ok;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [12:0] cfg_data = '0;
	int errors, pending, results_seen, boxes_ok;
	int cycle = 0;
	int words_sent = 0;
	bit hold_off = 1'b0;
	// mirror of the image and crop setup, so computes only touch written pixels
	int img_w = 256, img_h = 256, crop_l = 0, crop_t = 0, crop_w = 256, crop_h = 256;
	int tgt_w = 256, tgt_h = 256;

	always #1 clk = ~clk;

	box_average_image_scaler_top dut (.*);

	box_scale_checker chk (.*);

	// cycle limit
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > LIMIT) begin
			$display("timeout at cycle %0d", cycle);
			$display("FAILURE");
			$finish;
		end
	end

	// receiver: own stall pattern, plus one long hold-off on request
	always @(posedge clk) begin
		int mood;
		mood = $urandom_range(0, 99);
		if (hold_off)
			out_stall <= 1'b1;
		else if (cycle % 2000 < 500)
			out_stall <= 1'b0;
		else
			out_stall <= (mood < 40);
	end

	task automatic write_reg(input logic [2:0] idx, input int val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[12:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait out every pending result, then the block's own tail
	task automatic settle();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// one word, held until accepted; random gap afterwards when bursting
	task automatic send_word(input logic m, input int a, input int b, input int c,
			input bit gap);
		@(posedge clk);
		in_valid <= 1'b1;
		mode <= m;
		if (m == 1'b0) begin
			load_column <= a[7:0];
			load_row <= b[7:0];
			{red_in, green_in, blue_in} <= c[23:0];
			target_column <= 12'($urandom);
			target_row <= 12'($urandom);
		end else begin
			target_column <= a[11:0];
			target_row <= b[11:0];
			load_column <= 8'($urandom);
			load_row <= 8'($urandom);
			{red_in, green_in, blue_in} <= 24'($urandom);
		end
		do @(posedge clk); while (in_stall);
		in_valid <= 1'b0;
		words_sent++;
		if (gap && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 6)) @(posedge clk);
	endtask

	task automatic load(input int x, input int y, input int px);
		send_word(1'b0, x, y, px, 1'b1);
	endtask

	task automatic compute(input int x, input int y);
		send_word(1'b1, x, y, 0, 1'b1);
	endtask

	// fill a rectangle of the store with random pixels
	task automatic fill_image(input int x0, input int y0, input int w, input int h);
		for (int y = y0; y < y0 + h; y++)
			for (int x = x0; x < x0 + w; x++)
				load(x, y, $urandom);
	endtask

	task automatic set_geometry(input int iw, input int ih, input int cl, input int ct,
			input int cw, input int ch, input int tw, input int th);
		settle();
		write_reg(bais_pkg::REG_IMG_W, iw); write_reg(bais_pkg::REG_IMG_H, ih);
		write_reg(bais_pkg::REG_CROP_L, cl); write_reg(bais_pkg::REG_CROP_T, ct);
		write_reg(bais_pkg::REG_CROP_W, cw); write_reg(bais_pkg::REG_CROP_H, ch);
		write_reg(bais_pkg::REG_TGT_W, tw); write_reg(bais_pkg::REG_TGT_H, th);
		img_w = iw; img_h = ih; crop_l = cl; crop_t = ct;
		crop_w = cw; crop_h = ch; tgt_w = tw; tgt_h = th;
	endtask

	// compute words spread over the target, with a few out-of-range ones
	task automatic random_computes(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				compute($urandom_range(0, 4095), $urandom_range(0, 4095));
			else
				compute($urandom_range(0, (tgt_w > 0 ? tgt_w : 1) - 1),
					$urandom_range(0, (tgt_h > 0 ? tgt_h : 1) - 1));
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// small image: pixel values at the extremes
		set_geometry(8, 8, 0, 0, 8, 8, 8, 8);
		load(0, 0, 24'h000000);
		load(1, 0, 24'hFFFFFF);
		for (int y = 0; y < 8; y++)
			for (int x = 0; x < 8; x++)
				if (y > 0 || x > 1) load(x, y, $urandom);
		// equal sizes give a copy: the two extreme pixels and the far corner of the target
		compute(0, 0); compute(1, 0); compute(7, 7);
		// coordinates outside the target fail
		compute(8, 0); compute(0, 8); compute(4095, 4095);
		// loads past the image but inside the store are still written
		load(255, 255, 24'hA5A5A5);
		load(200, 3, 24'h5A5A5A);

		// downscale to a single pixel averages the whole crop
		set_geometry(8, 8, 0, 0, 8, 8, 1, 1);
		compute(0, 0);
		// upscale: spans widen to one pixel
		set_geometry(8, 8, 2, 3, 3, 2, 4096, 4096);
		compute(0, 0); compute(4095, 4095); compute(2000, 1000);
		// zero sizes fail
		set_geometry(8, 8, 0, 0, 0, 8, 4, 4); compute(0, 0);
		set_geometry(8, 8, 0, 0, 8, 0, 4, 4); compute(0, 0);
		set_geometry(8, 8, 0, 0, 8, 8, 0, 4); compute(0, 0);
		set_geometry(8, 8, 0, 0, 8, 8, 4, 0); compute(0, 0);
		// crop reaching past the image fails; bad image and target sizes fail
		set_geometry(8, 8, 1, 0, 8, 8, 4, 4); compute(0, 0);
		set_geometry(0, 8, 0, 0, 8, 8, 4, 4); compute(0, 0);
		set_geometry(300, 8, 0, 0, 8, 8, 4, 4); compute(0, 0);
		set_geometry(8, 8, 0, 0, 8, 8, 5000, 4); compute(0, 0);

		// long hold-off on the output while computes keep coming
		set_geometry(8, 8, 0, 0, 8, 8, 8, 8);
		hold_off = 1'b1;
		fork
			begin
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
			random_computes(6);
		join
		// pause until everything is back
		settle();

		// random phases: mostly small boxes, a few larger crops
		while (words_sent < 700) begin
			int iw, ih, cl, ct, cw, ch, tw, th, kind;
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				iw = $urandom_range(16, 24); ih = $urandom_range(16, 24);
			end else begin
				iw = $urandom_range(1, 10); ih = $urandom_range(1, 10);
			end
			cw = $urandom_range(1, iw); ch = $urandom_range(1, ih);
			cl = $urandom_range(0, iw - cw); ct = $urandom_range(0, ih - ch);
			tw = $urandom_range(1, 12); th = $urandom_range(1, 12);
			if (kind == 1) begin tw = 4096; th = $urandom_range(1, 4096); end
			set_geometry(iw, ih, cl, ct, cw, ch, tw, th);
			fill_image(cl, ct, cw, ch);
			random_computes($urandom_range(10, 30));
			// some stray loads past the image that never get read
			repeat ($urandom_range(0, 3))
				load($urandom_range(40, 255), $urandom_range(40, 255), $urandom);
		end

		// end at the highest crop corner and restore defaults
		set_geometry(256, 256, 255, 255, 1, 1, 1, 1);
		load(255, 255, 24'hFFFFFF);
		compute(0, 0);
		set_geometry(256, 256, 0, 0, 256, 256, 256, 256);
		compute(255, 255);
		settle();
		repeat (100) @(posedge clk);

		$display("sent %0d words, checked %0d results (%0d valid boxes)",
			words_sent, results_seen, boxes_ok);
		$display("covered copies, down and up scaling, crops and invalid setups");
		if (errors == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
